/* sv/gbc_pkg.sv */
package gbc_pkg;

    localparam int TAPS_DEF     = 220;
    localparam int MAX_FRAME_DEF = 16384;
    localparam int DEPTH_DEF    = 256;

    localparam int SIGMA        = 22;
    localparam int ROM_SIZE     = 256;
    localparam int ROM_W        = 19;
    localparam int SAMPLE_W     = 16;
    localparam int SIG_W        = 28;
    localparam int COUNT_W      = 14;
    localparam int ALPHA_W      = 16;
    localparam int AMP_W        = 24;
    localparam int DUR_W        = 14;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd1548;
    localparam longint unsigned SPREAD = 64'(2 * SIGMA * SIGMA);

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_AMP   = 2'd1;
    localparam logic [1:0] REG_DUR   = 2'd2;

    typedef logic [ROM_W-1:0] t_rom [0:ROM_SIZE-1];

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_item;

    // Unsigned quotient by shift and subtract; only used while building the table.
    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Gaussian point in Q0.31: series at 1/32 of the argument, squared five times.
    function automatic longint unsigned gauss_point(int off);
        longint unsigned sq;
        longint unsigned arg;
        longint unsigned y;
        longint unsigned term;
        longint          acc;
        longint unsigned v;
        sq   = longint'(off * off);
        arg  = udiv(sq << 31, SPREAD);
        y    = arg >> 5;
        term = 64'd1 << 31;
        acc  = 64'sd1 << 31;
        for (int t = 1; t <= 14; t++) begin
            term = udiv((term * y) >> 31, 64'(t));
            if (t % 2 == 1) acc = acc - longint'(term);
            else            acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        v = longint'(acc);
        for (int t = 0; t < 5; t++) begin
            v = (v * v + (64'd1 << 30)) >> 31;
        end
        return v;
    endfunction

    function automatic t_rom gauss_rom(int half);
        longint unsigned g [0:ROM_SIZE-1];
        longint unsigned total;
        t_rom            r;
        total = 0;
        for (int t = 0; t < ROM_SIZE; t++) begin
            g[t] = 0;
            if (t < 2 * half) g[t] = gauss_point(t - half);
            total = total + g[t];
        end
        for (int t = 0; t < ROM_SIZE; t++) begin
            if (total != 0) r[t] = ROM_W'(udiv((g[t] << 18) + (total >> 1), total));
            else            r[t] = '0;
        end
        return r;
    endfunction

endpackage

/* sv/gbc_ram.sv */
module gbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/gbc_front.sv */
module gbc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [gbc_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                            i_last,
    output logic                            o_item_valid,
    output gbc_pkg::t_item                  o_item,
    input  logic                            i_pop
);

    // Two-entry queue so the input side keeps moving while the engine works.
    gbc_pkg::t_item r_mem [0:1];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{sample: i_sample, last: i_last};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

/* sv/gbc_back.sv */
module gbc_back #(
    parameter int TAPS      = gbc_pkg::TAPS_DEF,
    parameter int MAX_FRAME = gbc_pkg::MAX_FRAME_DEF,
    parameter int DEPTH     = gbc_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_item_valid,
    input  gbc_pkg::t_item                      i_item,
    output logic                                o_pop,
    input  logic [gbc_pkg::ALPHA_W-1:0]         i_alpha,
    input  logic [gbc_pkg::AMP_W-1:0]           i_amp_thr,
    input  logic [gbc_pkg::DUR_W-1:0]           i_dur_thr,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [gbc_pkg::COUNT_W-1:0]         o_count
);

    localparam int HALF  = TAPS / 2;
    localparam int NT    = 2 * HALF;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(NT + 1);
    localparam int PW    = $clog2(MAX_FRAME);
    localparam int DW    = (PW > gbc_pkg::DUR_W) ? PW : gbc_pkg::DUR_W;
    localparam int SW    = gbc_pkg::SIG_W;
    localparam int XW    = gbc_pkg::SAMPLE_W;
    localparam int PRW   = XW + gbc_pkg::ROM_W + 1;
    localparam int ACW   = PRW + 9;
    localparam int MW    = SW + gbc_pkg::ALPHA_W + 1;
    localparam int LIM   = (NT < DEPTH) ? NT : DEPTH;
    localparam gbc_pkg::t_rom ROM = gbc_pkg::gauss_rom(HALF);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRITE = 4'd1;
    localparam logic [3:0] S_MAC   = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_RND   = 4'd4;
    localparam logic [3:0] S_D1    = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]                   r_state;
    logic signed [XW-1:0]         r_x;
    logic [AW-1:0]                r_ptr;
    logic [AW-1:0]                r_slot;
    logic [FW-1:0]                r_fill;
    logic [FW-1:0]                r_d;
    logic [FW-1:0]                r_lim;
    logic [FW-1:0]                r_flush;
    logic                         r_last;
    logic                         r_v1;
    logic                         r_v2;
    logic [gbc_pkg::ROM_W-1:0]    r_rom1;
    logic signed [PRW-1:0]        r_p;
    logic signed [ACW-1:0]        r_acc;
    logic signed [SW-1:0]         r_sm;
    logic signed [SW-1:0]         r_smprev;
    logic signed [SW-1:0]         r_diff;
    logic signed [MW-1:0]         r_prod;
    logic signed [SW-1:0]         r_avg;
    logic signed [SW-1:0]         r_rise_avg;
    logic                         r_sign;
    logic                         r_rise_open;
    logic [PW-1:0]                r_rise_idx;
    logic [PW-1:0]                r_pos;
    logic [gbc_pkg::COUNT_W-1:0]  r_total;
    logic                         r_ovalid;
    logic [gbc_pkg::COUNT_W-1:0]  r_odata;

    logic [XW-1:0]                rd;
    logic [FW-1:0]                n_fill;
    logic [7:0]                   rom_idx;
    logic signed [ACW-1:0]        acc_rnd;
    logic signed [MW-1:0]         prod_rnd;
    logic signed [SW-1:0]         step;
    logic signed [SW-1:0]         avg_new;
    logic                         up;
    logic signed [SW-1:0]         amp;
    logic [PW-1:0]                dur;
    logic                         qualifies;

    gbc_ram #(.WIDTH(XW), .DEPTH(DEPTH)) u_window (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_ptr),
        .i_wdata (r_x),
        .i_raddr (r_slot),
        .o_rdata (rd)
    );

    assign o_pop   = (r_state == S_IDLE) && !r_last && i_item_valid;
    assign o_valid = r_ovalid;
    assign o_count = r_odata;

    always_comb begin
        n_fill    = (r_fill < FW'(NT)) ? r_fill + 1'b1 : r_fill;
        rom_idx   = 8'(NT - 1 - int'(r_d));
        acc_rnd   = r_acc + ACW'(512);
        prod_rnd  = (r_prod + MW'(32768)) >>> 16;
        step      = prod_rnd[SW-1:0];
        avg_new   = r_avg + step;
        up        = !step[SW-1];
        amp       = avg_new - r_rise_avg;
        dur       = (r_pos >= r_rise_idx) ? r_pos - r_rise_idx
                                          : PW'(MAX_FRAME - int'(r_rise_idx) + int'(r_pos));
        qualifies = (amp > SW'($signed(i_amp_thr)))
                    && (DW'(dur) > DW'(i_dur_thr))
                    && (r_total < gbc_pkg::COUNT_MAX);
    end

    always_ff @(posedge i_clk) begin
        r_v1   <= 1'b0;
        r_v2   <= r_v1;
        r_rom1 <= ROM[rom_idx];
        r_p    <= $signed(rd) * $signed({1'b0, r_rom1});
        if (r_v2) r_acc <= r_acc + ACW'(r_p);

        unique case (r_state)
            S_IDLE: begin
                if (r_last) begin
                    if (r_flush != '0) begin
                        r_x     <= '0;
                        r_flush <= r_flush - 1'b1;
                        r_state <= S_WRITE;
                    end else begin
                        r_state <= S_OUT;
                    end
                end else if (i_item_valid) begin
                    r_x     <= i_item.sample;
                    r_last  <= i_item.last;
                    r_flush <= FW'(HALF - 1);
                    r_state <= S_WRITE;
                end
            end
            S_WRITE: begin
                r_ptr  <= (r_ptr == AW'(DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                r_slot <= r_ptr;
                r_fill <= n_fill;
                r_d    <= '0;
                r_lim  <= (int'(n_fill) < LIM) ? n_fill : FW'(LIM);
                r_acc  <= '0;
                r_state <= (n_fill >= FW'(HALF)) ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                r_v1   <= 1'b1;
                r_slot <= (r_slot == '0) ? AW'(DEPTH - 1) : r_slot - 1'b1;
                r_d    <= r_d + 1'b1;
                if (r_d == r_lim - 1'b1) r_state <= S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) r_state <= S_RND;
            end
            S_RND: begin
                r_sm    <= acc_rnd[SW+9:10];
                r_state <= S_D1;
            end
            S_D1: begin
                r_diff   <= (r_sm - r_smprev) - r_avg;
                r_smprev <= r_sm;
                r_state  <= S_MUL;
            end
            S_MUL: begin
                r_prod  <= $signed({1'b0, i_alpha}) * r_diff;
                r_state <= S_UPD;
            end
            S_UPD: begin
                r_avg <= avg_new;
                if (up && !r_sign) begin
                    r_rise_open <= 1'b1;
                    r_rise_idx  <= r_pos;
                    r_rise_avg  <= avg_new;
                end else if (!up && r_sign && r_rise_open) begin
                    if (qualifies) r_total <= r_total + 1'b1;
                    r_rise_open <= 1'b0;
                end
                r_sign  <= up;
                r_pos   <= (r_pos == PW'(MAX_FRAME - 1)) ? '0 : r_pos + 1'b1;
                r_state <= S_IDLE;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    r_odata     <= r_total;
                    r_last      <= 1'b0;
                    r_fill      <= '0;
                    r_smprev    <= '0;
                    r_avg       <= '0;
                    r_sign      <= 1'b0;
                    r_rise_open <= 1'b0;
                    r_rise_idx  <= '0;
                    r_rise_avg  <= '0;
                    r_pos       <= '0;
                    r_total     <= '0;
                    r_state     <= S_IDLE;
                end
            end
            default: r_state <= S_IDLE;
        endcase

        if (r_state == S_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
        else if (i_ready) r_ovalid <= 1'b0;

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_flush     <= '0;
            r_last      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_smprev    <= '0;
            r_avg       <= '0;
            r_sign      <= 1'b0;
            r_rise_open <= 1'b0;
            r_rise_idx  <= '0;
            r_rise_avg  <= '0;
            r_pos       <= '0;
            r_total     <= '0;
            r_ovalid    <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(NT))
        else $error("window fill count beyond tap count");
    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("accumulate stage without a product");
    a_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_last && r_flush == '0))
        else $error("count given before the flush finished");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");
`endif

endmodule

/* sv/gas_bout_counter_unit.sv */
// One sample is worked on at a time; an accepted transfer waits in a two-entry queue until
// the engine is idle. Per sample the engine writes the window RAM, then runs N = min(fill, 220)
// taps through one shared multiply-accumulate reading the window RAM one word a cycle, drains,
// rounds and updates the average and bout count; before the 110th sample of a frame only the
// write is done. The last sample adds 109 flush passes of zero samples, then the count is output.
// Synchronous active-low reset clears control state and restores register defaults.
module gas_bout_counter_unit #(
    parameter int TAPS      = gbc_pkg::TAPS_DEF,
    parameter int MAX_FRAME = gbc_pkg::MAX_FRAME_DEF,
    parameter int DEPTH     = gbc_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] sample
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [13:0] bout_count, [15:14] zero
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [gbc_pkg::ALPHA_W-1:0] r_alpha;
    logic [gbc_pkg::AMP_W-1:0]   r_amp_thr;
    logic [gbc_pkg::DUR_W-1:0]   r_dur_thr;
    logic                        wr;
    logic                        item_valid;
    gbc_pkg::t_item              item;
    logic                        pop;
    logic [gbc_pkg::COUNT_W-1:0] count;

    assign o_pready = 1'b1;
    assign wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= gbc_pkg::ALPHA_RST;
            r_amp_thr <= '0;
            r_dur_thr <= '0;
        end else if (wr) begin
            unique case (i_paddr[3:2])
                gbc_pkg::REG_ALPHA: r_alpha   <= i_pwdata[gbc_pkg::ALPHA_W-1:0];
                gbc_pkg::REG_AMP:   r_amp_thr <= i_pwdata[gbc_pkg::AMP_W-1:0];
                gbc_pkg::REG_DUR:   r_dur_thr <= i_pwdata[gbc_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            gbc_pkg::REG_ALPHA: o_prdata = 32'(r_alpha);
            gbc_pkg::REG_AMP:   o_prdata = 32'(r_amp_thr);
            gbc_pkg::REG_DUR:   o_prdata = 32'(r_dur_thr);
            default:            o_prdata = '0;
        endcase
    end

    gbc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_sample     (i_s_axis_tdata),
        .i_last       (i_s_axis_tlast),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    gbc_back #(.TAPS(TAPS), .MAX_FRAME(MAX_FRAME), .DEPTH(DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .i_alpha      (r_alpha),
        .i_amp_thr    (r_amp_thr),
        .i_dur_thr    (r_dur_thr),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_count      (count)
    );

    assign o_m_axis_tdata = {2'b00, count};

endmodule
